FILE: hw/rtl/assert_macros.svh
// Assertion helpers for the RTL. In simulation builds each macro expands to a labeled concurrent
// assertion clocked on the rising edge and disabled while reset is low; otherwise it expands to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("Assertion failed.");

`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("Assertion failed.");

`else

`define ASSERT_IMPL(label, clk, rst_n, ante, cons)

`define ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

FILE: hw/rtl/sdi_trd_pkg.sv
`default_nettype none

package sdi_trd_pkg;

	localparam int unsigned OFFSET_BITS_DEFAULT = 32;
	localparam int unsigned PATTERN_BYTES = 16;
	localparam int unsigned HELD_BYTES = PATTERN_BYTES - 1;
	localparam int unsigned RESULT_BITS = 32;
	localparam int unsigned KIND_COUNT = 4;

	typedef enum logic [1:0] {
		KIND_SAV_BLANK  = 2'd0,
		KIND_EAV_BLANK  = 2'd1,
		KIND_SAV_ACTIVE = 2'd2,
		KIND_EAV_ACTIVE = 2'd3
	} match_kind_t;

	typedef logic [7:0] byte_t;
	typedef byte_t [PATTERN_BYTES-1:0] window_t;

	// Byte j of the multiplexed pattern: every byte pair of the base is sent twice.
	function automatic byte_t pattern_byte(input match_kind_t kind, input int unsigned j);
		int unsigned idx;
		byte_t value;
		idx = 2 * (j >> 2) + (j & 1);
		if (idx >= 7) begin
			unique case (kind)
				KIND_SAV_BLANK:  value = 8'hAC;
				KIND_EAV_BLANK:  value = 8'hDB;
				KIND_SAV_ACTIVE: value = 8'h00;
				KIND_EAV_ACTIVE: value = 8'h74;
				default:         value = 8'h00;
			endcase
		end else begin
			unique case (idx)
				0:       value = 8'h03;
				1:       value = 8'hFF;
				6:       value = 8'h02;
				default: value = 8'h00;
			endcase
		end
		return value;
	endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/sdi_trd_in_if.sv
`default_nettype none

interface sdi_trd_in_if;
	import sdi_trd_pkg::*;

	logic  valid;
	logic  ready;
	byte_t data_byte;
	logic  buffer_start;

	modport source (output valid, output data_byte, output buffer_start, input ready);
	modport sink (input valid, input data_byte, input buffer_start, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/sdi_trd_out_if.sv
`default_nettype none

interface sdi_trd_out_if;
	import sdi_trd_pkg::*;

	logic                   valid;
	logic                   ready;
	logic [1:0]             match_kind;
	logic [RESULT_BITS-1:0] match_offset;
	logic [RESULT_BITS-1:0] match_distance;

	modport source (output valid, output match_kind, output match_offset,
		output match_distance, input ready);
	modport sink (input valid, input match_kind, input match_offset,
		input match_distance, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/sdi_timing_reference_detector_core.sv
// Requests are registered in the first stage; a match there goes to the output register once it is free.
// Throughput: one request per cycle unless stalled; the window compare is a single registered stage.
// The input stalls only while a match waits in the first stage behind an unread result.
// Reset (arst_n low, asynchronous) clears the window, the byte count, the SAV and EAV
// history and all valid flags; no clearing pass is needed afterwards.
`default_nettype none

`include "assert_macros.svh"

module sdi_timing_reference_detector_core #(
	parameter int unsigned OFFSET_BITS = sdi_trd_pkg::OFFSET_BITS_DEFAULT
) (
	input  logic          clk,
	input  logic          arst_n,
	sdi_trd_in_if.sink    stream,
	sdi_trd_out_if.source result
);
	import sdi_trd_pkg::*;

	localparam logic [OFFSET_BITS-1:0] CNT_MAX = '1;
	localparam logic [OFFSET_BITS-1:0] HELD = OFFSET_BITS'(HELD_BYTES);

	byte_t [HELD_BYTES-1:0]  window_q;
	logic [OFFSET_BITS-1:0]  count_q;

	window_t                 window_s1;
	logic [OFFSET_BITS-1:0]  idx_s1;
	logic                    start_s1;
	logic                    valid_s1;

	logic                    sav_seen_q;
	logic                    eav_seen_q;
	logic [OFFSET_BITS-1:0]  last_sav_q;
	logic [OFFSET_BITS-1:0]  last_eav_q;

	logic                    out_valid_q;
	match_kind_t             kind_q;
	logic [RESULT_BITS-1:0]  offset_q;
	logic [RESULT_BITS-1:0]  distance_q;

	logic                    accept;
	window_t                 full_in;
	logic [OFFSET_BITS-1:0]  count_eff;
	logic [OFFSET_BITS-1:0]  count_next;

	logic                    hit_any;
	match_kind_t             kind;
	logic                    s1_hit;
	logic                    is_eav;
	logic                    seen_eff;
	logic [OFFSET_BITS-1:0]  last_eff;
	logic [OFFSET_BITS-1:0]  offset;
	logic [OFFSET_BITS-1:0]  distance;
	logic [RESULT_BITS-1:0]  offset_out;
	logic [RESULT_BITS-1:0]  dist_out;
	logic                    out_free;
	logic                    s1_adv;

	// A new buffer starts from an empty window and a zero count.
	assign accept = stream.valid && stream.ready;
	assign full_in = {stream.data_byte, (stream.buffer_start ? {HELD_BYTES{8'h00}} : window_q)};
	assign count_eff = stream.buffer_start ? '0 : count_q;
	assign count_next = (count_eff != CNT_MAX) ? count_eff + 1'b1 : count_eff;

	always_comb begin
		hit_any = 1'b0;
		kind = KIND_SAV_BLANK;
		for (int unsigned k = 0; k < KIND_COUNT; k++) begin
			logic eq;
			eq = 1'b1;
			for (int unsigned j = 0; j < PATTERN_BYTES; j++) begin
				eq = eq && (window_s1[j] == pattern_byte(match_kind_t'(2'(k)), j));
			end
			if (eq && !hit_any) begin
				hit_any = 1'b1;
				kind = match_kind_t'(2'(k));
			end
		end
	end

	assign s1_hit = valid_s1 && hit_any && (idx_s1 >= HELD);
	assign offset = idx_s1 - HELD;
	assign is_eav = kind[0];
	assign seen_eff = !start_s1 && (is_eav ? eav_seen_q : sav_seen_q);
	assign last_eff = is_eav ? last_eav_q : last_sav_q;
	assign distance = seen_eff ? offset - last_eff : '0;

	if (OFFSET_BITS > RESULT_BITS) begin : g_clamp
		assign offset_out = (|offset[OFFSET_BITS-1:RESULT_BITS]) ? '1 : offset[RESULT_BITS-1:0];
		assign dist_out = (|distance[OFFSET_BITS-1:RESULT_BITS]) ? '1 :
			distance[RESULT_BITS-1:0];
	end else begin : g_extend
		assign offset_out = RESULT_BITS'(offset);
		assign dist_out = RESULT_BITS'(distance);
	end

	assign out_free = !out_valid_q || result.ready;
	assign s1_adv = valid_s1 && (!s1_hit || out_free);
	assign stream.ready = !valid_s1 || s1_adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			count_q <= '0;
			valid_s1 <= 1'b0;
			sav_seen_q <= 1'b0;
			eav_seen_q <= 1'b0;
			last_sav_q <= '0;
			last_eav_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				window_q <= full_in[PATTERN_BYTES-1:1];
				count_q <= count_next;
			end
			if (stream.ready) begin
				valid_s1 <= stream.valid;
			end
			if (s1_adv) begin
				if (s1_hit && is_eav) begin
					last_eav_q <= offset;
					eav_seen_q <= 1'b1;
				end else if (start_s1) begin
					eav_seen_q <= 1'b0;
				end
				if (s1_hit && !is_eav) begin
					last_sav_q <= offset;
					sav_seen_q <= 1'b1;
				end else if (start_s1) begin
					sav_seen_q <= 1'b0;
				end
			end
			if (out_free) begin
				out_valid_q <= s1_hit;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			window_s1 <= full_in;
			idx_s1 <= count_eff;
			start_s1 <= stream.buffer_start;
		end
		if (s1_hit && out_free) begin
			kind_q <= kind;
			offset_q <= offset_out;
			distance_q <= dist_out;
		end
	end

	assign result.valid = out_valid_q;
	assign result.match_kind = kind_q;
	assign result.match_offset = offset_q;
	assign result.match_distance = distance_q;

	`ASSERT_IMPL(a_sav_seen_rise, clk, arst_n, $rose(sav_seen_q), $past(s1_adv && s1_hit && !is_eav))
	`ASSERT_IMPL(a_eav_seen_rise, clk, arst_n, $rose(eav_seen_q), $past(s1_adv && s1_hit && is_eav))
	`ASSERT_NEXT(a_count_moves, clk, arst_n, accept, count_q != '0)
	`ASSERT_NEXT(a_stall_holds, clk, arst_n, valid_s1 && s1_hit && !out_free, valid_s1 && $stable(idx_s1))

endmodule

`default_nettype wire
